[sv/iss_pkg.sv]
package iss_pkg;

  localparam int DEFAULT_STORE_DEPTH = 64;
  localparam int VALUE_W = 32;
  localparam int RANK_W = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_EMIT,
    ST_DRAIN,
    ST_DROP
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_search;
    logic rd_emit;
    logic wr_shift;
    logic wr_insert;
    logic drop_out;
    logic clear_count;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic j_zero;
    logic gt;
    logic k_last;
    logic eos;
  } dp_status_t;

endpackage

[sv/iss_ctrl.sv]
module iss_ctrl
  import iss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = status.full ? ST_DROP : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.j_zero) begin
          cmd.wr_insert = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.rd_search = 1'b1;
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (status.gt) begin
          cmd.wr_shift = 1'b1;
          state_next = ST_SEARCH;
        end else begin
          cmd.wr_insert = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.rd_emit = 1'b1;
        if (status.k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read is in the pipe, count is still needed for its step number
        cmd.clear_count = status.eos;
        state_next = ST_IDLE;
      end
      ST_DROP: begin
        cmd.drop_out = 1'b1;
        cmd.clear_count = status.eos;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/iss_datapath.sv]
module iss_datapath
  import iss_pkg::*;
#(
  parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  logic signed [VALUE_W-1:0] sample_value,
  input  logic                     end_of_set,
  output logic                     result_valid,
  output logic signed [VALUE_W-1:0] sorted_value,
  output logic [RANK_W-1:0]        rank_position,
  output logic [RANK_W-1:0]        step_number,
  output logic                     run_last,
  output logic                     overflow_flag
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  logic [VALUE_W-1:0] mem [STORE_DEPTH];
  logic [VALUE_W-1:0] rdata;

  logic [CW-1:0] count;
  logic [CW-1:0] j;
  logic [AW-1:0] k;
  logic [VALUE_W-1:0] v;
  logic eos;

  logic [CW-1:0] j_dec;
  logic [AW-1:0] raddr;
  logic          we;
  logic [VALUE_W-1:0] wdata;
  logic          re;

  // stage aligned with rdata during the emit run
  logic              p_valid;
  logic [RANK_W-1:0] p_rank;
  logic [RANK_W-1:0] p_step;
  logic              p_last;

  assign j_dec = j - 1'b1;
  assign raddr = cmd.rd_emit ? k : j_dec[AW-1:0];
  assign re    = cmd.rd_emit | cmd.rd_search;
  assign we    = cmd.wr_shift | cmd.wr_insert;
  assign wdata = cmd.wr_shift ? rdata : v;

  assign status.full   = (count >= CW'(STORE_DEPTH));
  assign status.j_zero = (j == '0);
  assign status.gt     = ($signed(rdata) > $signed(v));
  assign status.k_last = ({{(CW-AW){1'b0}}, k} == (count - 1'b1));
  assign status.eos    = eos;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[j[AW-1:0]] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v   <= sample_value;
      eos <= end_of_set;
      j   <= count;
      k   <= '0;
    end else begin
      if (cmd.wr_shift) begin
        j <= j_dec;
      end
      if (cmd.rd_emit) begin
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear_count) begin
      count <= '0;
    end else if (cmd.wr_insert) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      p_valid      <= cmd.rd_emit;
      result_valid <= p_valid | cmd.drop_out;
    end
  end

  always_ff @(posedge clk) begin
    p_rank <= RANK_W'(k);
    p_step <= RANK_W'(count - 1'b1);
    p_last <= status.k_last;
    if (cmd.drop_out) begin
      sorted_value  <= '0;
      rank_position <= '0;
      step_number   <= '0;
      run_last      <= 1'b1;
      overflow_flag <= 1'b1;
    end else begin
      sorted_value  <= rdata;
      rank_position <= p_rank;
      step_number   <= p_step;
      run_last      <= p_last;
      overflow_flag <= 1'b0;
    end
  end

endmodule

[sv/insertion_sort_step_trace_top.sv]
// Incremental insertion sort with a step trace. Pulse start while busy is low to
// insert sample_value; larger stored entries move up one place, and equal keys keep
// arrival order. The block then emits the whole sorted prefix, smallest first, one
// element per cycle on consecutive result_valid strobes, with run_last on the final
// one. The receiver cannot stall: each result is on the ports for exactly one cycle.
// An item that arrives with n stored entries goes through an accept step, then a
// search of one memory read and then one compare and write per entry looked at,
// emit reads of all n + 1 entries and a drain step; its last result is on the ports in
// the first cycle that busy is low again. With end_of_set the store is emptied
// after the run. A full store drops the value and gives a single result with
// overflow_flag set.
module insertion_sort_step_trace_top
  import iss_pkg::*;
#(
  parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [VALUE_W-1:0] sample_value,
  input  logic                     end_of_set,
  output logic                     result_valid,
  output logic signed [VALUE_W-1:0] sorted_value,
  output logic [RANK_W-1:0]        rank_position,
  output logic [RANK_W-1:0]        step_number,
  output logic                     run_last,
  output logic                     overflow_flag
);

  dp_cmd_t    cmd;
  dp_status_t status;

  iss_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  iss_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample_value  (sample_value),
    .end_of_set    (end_of_set),
    .result_valid  (result_valid),
    .sorted_value  (sorted_value),
    .rank_position (rank_position),
    .step_number   (step_number),
    .run_last      (run_last),
    .overflow_flag (overflow_flag)
  );

endmodule

[sv/iss_checker.sv]
module iss_checker
  import iss_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input logic [RANK_W-1:0] rank_position,
  input logic [RANK_W-1:0] step_number,
  input logic              run_last,
  input logic              overflow_flag
);

  // a run comes out without gaps
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !run_last |=> result_valid)
    else $error("run broken before its last item");

  a_rank_steps: assert property (@(posedge clk) disable iff (rst)
    result_valid && !run_last |=> rank_position == $past(rank_position) + 1'b1)
    else $error("rank does not advance by one");

  a_last_rank: assert property (@(posedge clk) disable iff (rst)
    result_valid && run_last && !overflow_flag |-> rank_position == step_number)
    else $error("last item rank differs from step number");

  a_overflow_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow_flag |-> run_last && rank_position == '0)
    else $error("overflow result is not a single item");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

endmodule

bind insertion_sort_step_trace_top iss_checker u_iss_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_valid  (result_valid),
  .rank_position (rank_position),
  .step_number   (step_number),
  .run_last      (run_last),
  .overflow_flag (overflow_flag)
);
